@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the countdown timer.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define HMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles
`define HMS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/hmsct_pkg.sv @@
// Shared types, codes and helper functions of the hours:minutes:seconds timer.
// Used by hmsct_step, hms_countdown_timer and hmsct_checker; depends on nothing.
package hmsct_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int TIME_W      = 7;

  typedef enum logic [1:0] {
    PH_READY    = 2'd0,
    PH_COUNTING = 2'd1,
    PH_SETUP    = 2'd2,
    PH_FINISHED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_KEY   = 2'd1,
    MODE_EXIT  = 2'd2,
    MODE_ENTER = 2'd3
  } mode_t;

  // Key codes
  localparam logic [7:0] KEY_PLUS   = 8'h2B;
  localparam logic [7:0] KEY_ZERO   = 8'h30;
  localparam logic [7:0] KEY_SLASH  = 8'h2F;
  localparam logic [1:0] DIGIT_TAG  = 2'b11;

  // Setup digit positions, tens of hours first
  localparam logic [2:0] POS_NONE     = 3'd0;
  localparam logic [2:0] POS_SEC_UNIT = 3'd1;
  localparam logic [2:0] POS_SEC_TENS = 3'd2;
  localparam logic [2:0] POS_MIN_UNIT = 3'd3;
  localparam logic [2:0] POS_MIN_TENS = 3'd4;
  localparam logic [2:0] POS_HRS_UNIT = 3'd5;
  localparam logic [2:0] POS_HRS_TENS = 3'd6;

  localparam logic [3:0]        TENS_MAX  = 4'd5;
  localparam logic [TIME_W-1:0] MS_MAX    = 7'd59;
  localparam logic [1:0]        TICK_STEP = 2'd3;

  typedef struct packed {
    phase_t              phase;
    logic [TIME_W-1:0]   hours;
    logic [TIME_W-1:0]   minutes;
    logic [TIME_W-1:0]   seconds;
    logic [TIME_W-1:0]   p_hours;
    logic [TIME_W-1:0]   p_minutes;
    logic [TIME_W-1:0]   p_seconds;
    logic [1:0]          tick_cnt;
    logic                blink;
    logic [2:0]          digit_pos;
    logic                clk_req;
  } state_t;

  typedef struct packed {
    logic                handled;
    logic                show_clock;
    logic                blank_digit;
    logic                beep;
    logic                colon_on;
    logic [2:0]          setup_position;
    logic [1:0]          phase;
    logic [TIME_W-1:0]   seconds_bcd;
    logic [TIME_W-1:0]   minutes_bcd;
    logic [TIME_W-1:0]   hours_bcd;
  } result_t;

  localparam state_t RESET_STATE = '{
    phase:     PH_READY,
    hours:     7'd0,
    minutes:   7'd5,
    seconds:   7'd0,
    p_hours:   7'd0,
    p_minutes: 7'd5,
    p_seconds: 7'd0,
    tick_cnt:  2'd0,
    blink:     1'b0,
    digit_pos: POS_NONE,
    clk_req:   1'b0
  };

  // Quotient by ten through the reciprocal 205/2048, exact below 1024
  function automatic logic [3:0] div10(input logic [TIME_W-1:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] rem10(input logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] t;
    t = v - 7'(div10(v)) * 7'd10;
    return t[3:0];
  endfunction

  function automatic logic [TIME_W-1:0] to_bcd(input logic [TIME_W-1:0] v);
    logic [3:0] q;
    q = div10(v);
    return {q[2:0], rem10(v)};
  endfunction

  function automatic logic [TIME_W-1:0] set_tens(input logic [TIME_W-1:0] v,
                                                 input logic [3:0] d);
    return 7'(rem10(v)) + 7'(d) * 7'd10;
  endfunction

  function automatic logic [TIME_W-1:0] set_units(input logic [TIME_W-1:0] v,
                                                  input logic [3:0] d);
    return v - 7'(rem10(v)) + 7'(d);
  endfunction

  function automatic state_t load_preset(input state_t s);
    state_t r;
    r          = s;
    r.tick_cnt = 2'd0;
    r.hours    = s.p_hours;
    r.minutes  = s.p_minutes;
    r.seconds  = s.p_seconds;
    return r;
  endfunction

  function automatic state_t save_preset(input state_t s);
    state_t r;
    r           = s;
    r.p_hours   = s.hours;
    r.p_minutes = s.minutes;
    r.p_seconds = s.seconds;
    return r;
  endfunction

endpackage

@@ rtl/core/hmsct_step.sv @@
// Next-state and result logic of the timer for one event word.
// Depends on hmsct_pkg.
module hmsct_step (
  input  hmsct_pkg::state_t  cur,
  input  hmsct_pkg::mode_t   mode,
  input  logic [7:0]         key,
  input  logic               set_pressed,
  output hmsct_pkg::state_t  nxt,
  output hmsct_pkg::result_t res
);
  import hmsct_pkg::*;

  state_t     n;
  logic       beep;
  logic       blank;
  logic       handled;
  logic [3:0] d;
  logic       is_digit;

  assign d        = key[3:0];
  assign is_digit = (key[5:4] == DIGIT_TAG);

  always_comb begin
    n       = cur;
    beep    = 1'b0;
    blank   = 1'b0;
    handled = 1'b0;
    unique case (mode)
      MODE_TICK: begin
        // Set button: enter or leave setup
        if (set_pressed) begin
          if (n.phase == PH_READY) begin
            n           = load_preset(n);
            n.digit_pos = POS_HRS_TENS;
            n.phase     = PH_SETUP;
          end else if (n.phase == PH_SETUP) begin
            n       = save_preset(n);
            n.phase = PH_READY;
          end
        end
        if (n.phase == PH_FINISHED) begin
          n.blink = ~n.blink;
          beep    = n.blink;
        end else begin
          // Count down with borrow on every fourth tick
          if (n.phase == PH_COUNTING) begin
            n.tick_cnt = n.tick_cnt + 2'd1;
            if (n.tick_cnt == TICK_STEP) begin
              priority if (n.seconds == '0 && n.minutes == '0 && n.hours == '0) begin
                n.phase = PH_FINISHED;
              end else if (n.seconds == '0 && n.minutes != '0) begin
                n.seconds = MS_MAX;
                n.minutes = n.minutes - 7'd1;
              end else if (n.seconds == '0) begin
                n.hours   = n.hours - 7'd1;
                n.minutes = MS_MAX;
                n.seconds = MS_MAX;
              end else begin
                n.seconds = n.seconds - 7'd1;
              end
            end
          end
          // Blink the digit under entry unless the clock is on show
          if (!n.clk_req && n.phase == PH_SETUP) begin
            n.blink = ~n.blink;
            blank   = n.blink;
          end
        end
      end
      MODE_KEY: begin
        n.clk_req = 1'b0;
        if (n.phase == PH_SETUP) begin
          handled = 1'b1;
          // Digit entry, tens digits limited to five
          if (is_digit) begin
            unique case (n.digit_pos)
              POS_HRS_TENS: if (d <= TENS_MAX) begin
                n.hours     = set_tens(n.hours, d);
                n.digit_pos = POS_HRS_UNIT;
              end
              POS_HRS_UNIT: begin
                n.hours     = set_units(n.hours, d);
                n.digit_pos = POS_MIN_TENS;
              end
              POS_MIN_TENS: if (d <= TENS_MAX) begin
                n.minutes   = set_tens(n.minutes, d);
                n.digit_pos = POS_MIN_UNIT;
              end
              POS_MIN_UNIT: begin
                n.minutes   = set_units(n.minutes, d);
                n.digit_pos = POS_SEC_TENS;
              end
              POS_SEC_TENS: if (d <= TENS_MAX) begin
                n.seconds   = set_tens(n.seconds, d);
                n.digit_pos = POS_SEC_UNIT;
              end
              POS_SEC_UNIT: begin
                n.seconds = set_units(n.seconds, d);
                n         = save_preset(n);
                n.phase   = PH_READY;
              end
              default: begin
              end
            endcase
          end
        end else begin
          priority if (key == KEY_PLUS) begin
            if (n.phase == PH_COUNTING) begin
              n.phase = PH_READY;
            end else if (n.phase == PH_READY) begin
              n.phase = PH_COUNTING;
            end
            handled = (n.phase != PH_COUNTING);
          end else if (key == KEY_ZERO) begin
            if (n.phase == PH_READY || n.phase == PH_FINISHED) begin
              n       = load_preset(n);
              n.phase = PH_READY;
            end
            handled = (n.phase != PH_COUNTING);
          end else if (key == KEY_SLASH) begin
            n.clk_req = 1'b1;
            handled   = (n.phase != PH_COUNTING);
          end else begin
            handled = 1'b1;
          end
        end
      end
      MODE_EXIT: begin
        // Skip to the next digit, or leave the current phase
        unique case (n.phase)
          PH_SETUP: begin
            n.digit_pos = n.digit_pos - 3'd1;
            if (n.digit_pos == POS_NONE) begin
              n       = save_preset(n);
              n.phase = PH_READY;
            end
            handled = 1'b1;
          end
          PH_FINISHED: begin
            n       = load_preset(n);
            n.phase = PH_READY;
            handled = 1'b1;
          end
          PH_COUNTING: begin
            n.phase = PH_READY;
            handled = 1'b1;
          end
          PH_READY: begin
            handled = 1'b0;
          end
        endcase
      end
      MODE_ENTER: begin
        n       = load_preset(n);
        n.phase = PH_READY;
      end
    endcase
  end

  // Build the result word from the updated state
  always_comb begin
    res.hours_bcd      = to_bcd(n.hours);
    res.minutes_bcd    = to_bcd(n.minutes);
    res.seconds_bcd    = to_bcd(n.seconds);
    res.phase          = n.phase;
    res.setup_position = (n.phase == PH_SETUP) ? n.digit_pos : POS_NONE;
    res.colon_on       = n.tick_cnt[1];
    res.beep           = beep;
    res.blank_digit    = blank;
    res.show_clock     = n.clk_req;
    res.handled        = handled;
  end

  assign nxt = n;

endmodule

@@ rtl/core/hms_countdown_timer.sv @@
// Top level of the hours:minutes:seconds countdown timer.
// Depends on hmsct_pkg and hmsct_step.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+-----------------
//   in_*     | in  | tuser: mode; tdata: key, set_pressed      | tvalid / tready
//   out_*    | out | tdata: BCD time, phase, position, flags   | tvalid / tready
//
// One event word per cycle while the output is not stalled; a taken word passes the input
// register, then the state update into the output register, before its result leaves.
// rst_n is synchronous: state returns to ready with a 00:05:00 preset.
// A stalled result holds the output register; the input register still takes
// one more word, so a word per cycle flows whenever out_tready stays high.
module hms_countdown_timer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] key, [8] set_pressed, [15:9] zero
  input  logic [hmsct_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] mode
  input  logic [hmsct_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [6:0] hours_bcd, [13:7] minutes_bcd, [20:14] seconds_bcd, [22:21] phase,
  // [25:23] setup_position, [26] colon_on, [27] beep, [28] blank_digit,
  // [29] show_clock, [30] handled, [31] zero
  output logic [hmsct_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import hmsct_pkg::*;

  logic      s1_valid_r;
  mode_t     s1_mode_r;
  logic [7:0] s1_key_r;
  logic      s1_set_r;
  state_t    state_r;
  state_t    state_nxt;
  result_t   res;
  logic      out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic      s1_adv;

  assign s1_adv    = s1_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  hmsct_step u_step (
    .cur         (state_r),
    .mode        (s1_mode_r),
    .key         (s1_key_r),
    .set_pressed (s1_set_r),
    .nxt         (state_nxt),
    .res         (res)
  );

  // Input register: capture the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s1_mode_r <= mode_t'(in_tuser);
      s1_key_r  <= in_tdata[7:0];
      s1_set_r  <= in_tdata[8];
    end
  end

  // Commit the state and load the result when the word moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= RESET_STATE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (s1_adv) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_tdata_r <= {1'b0, res};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ rtl/core/hmsct_checker.sv @@
// Port-level checker of the countdown timer, bound into the top level.
// Depends on hmsct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hmsct_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [hmsct_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic [hmsct_pkg::IN_TUSER_W-1:0]   in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [hmsct_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import hmsct_pkg::*;

  logic [1:0] out_phase;
  logic [2:0] out_pos;
  logic       out_beep;

  // Pick the phase, position and beep fields out of the result word
  assign out_phase = out_tdata[22:21];
  assign out_pos   = out_tdata[25:23];
  assign out_beep  = out_tdata[27];

  // A waiting event word stays offered and unchanged until taken
  `HMS_ASSERT(a_in_hold, in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser), "event word changed")

  // A stalled result word stays offered and unchanged
  `HMS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word dropped or changed")

  // No result is offered in the cycle after a reset cycle
  `HMS_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "result offered after reset")

  // Beep only while finished
  `HMS_ASSERT(a_beep_phase, out_tvalid && out_beep |-> out_phase == PH_FINISHED, "beep outside finished")

  // In setup the digit position is always one of the six digits
  `HMS_ASSERT(a_setup_pos, out_tvalid && out_phase == PH_SETUP |-> out_pos != POS_NONE && out_pos <= POS_HRS_TENS, "bad setup position")

endmodule

bind hms_countdown_timer hmsct_checker u_hmsct_checker (.*);

@@ tb/sv/hms_countdown_timer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the hours:minutes:seconds countdown timer.
// Depends on hmsct_pkg and hms_countdown_timer; every result word is predicted here.
module hms_countdown_timer_tb;
  import hmsct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1480;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;

  // Predicted timer state
  typedef struct {
    phase_t            ph;
    logic [TIME_W-1:0] hrs, mins, secs;
    logic [TIME_W-1:0] pre_h, pre_m, pre_s;
    logic [1:0]        ticks;
    logic              blink;
    logic [2:0]        pos;
    logic              clk_req;
  } timer_state_t;

  // Expected result word, field by field
  typedef struct {
    logic [TIME_W-1:0] hours_bcd, minutes_bcd, seconds_bcd;
    logic [1:0]        phase;
    logic [2:0]        setup_position;
    logic              colon_on, beep, blank_digit, show_clock, handled;
  } timer_word_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  timer_state_t tmr;
  timer_word_t  due_words[$];
  int           err_cnt     = 0;
  int           sent_cnt    = 0;
  int           checked_cnt = 0;
  int           alarm_cnt   = 0;
  int           preset_cnt  = 0;
  int           rx_wait     = 0;
  bit           tx_idle     = 1'b1;
  bit           rx_idle     = 1'b1;
  logic         rx_held     = 1'b0;
  event         rx_hold_ev;
  int unsigned  cycle_cnt   = 0;

  hms_countdown_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [TIME_W-1:0] bcd_of(input logic [TIME_W-1:0] v);
    int q;
    int r;
    q = int'(v) / 10;
    r = int'(v) % 10;
    return TIME_W'((q << 4) | r);
  endfunction

  function automatic logic [TIME_W-1:0] with_tens(input logic [TIME_W-1:0] v, input int d);
    return TIME_W'(int'(v) % 10 + d * 10);
  endfunction

  function automatic logic [TIME_W-1:0] with_units(input logic [TIME_W-1:0] v, input int d);
    return TIME_W'(int'(v) - int'(v) % 10 + d);
  endfunction

  function automatic void reload_preset();
    tmr.ticks = 2'd0;
    tmr.hrs   = tmr.pre_h;
    tmr.mins  = tmr.pre_m;
    tmr.secs  = tmr.pre_s;
  endfunction

  function automatic void store_preset();
    tmr.pre_h = tmr.hrs;
    tmr.pre_m = tmr.mins;
    tmr.pre_s = tmr.secs;
    preset_cnt++;
  endfunction

  // Apply one event to the predicted state and build the word it produces
  function automatic timer_word_t advance_timer(input mode_t m, input logic [7:0] k,
                                                input logic set_btn);
    timer_word_t w;
    int          d;
    logic        beep_o;
    logic        blank_o;
    logic        used_o;
    beep_o  = 1'b0;
    blank_o = 1'b0;
    used_o  = 1'b0;
    d       = int'(k[3:0]);
    case (m)
      MODE_TICK: begin
        // set button only acts in ready (enter setup) and setup (save and leave)
        if (set_btn && tmr.ph == PH_READY) begin
          reload_preset();
          tmr.pos = POS_HRS_TENS;
          tmr.ph  = PH_SETUP;
        end else if (set_btn && tmr.ph == PH_SETUP) begin
          store_preset();
          tmr.ph = PH_READY;
        end
        if (tmr.ph == PH_FINISHED) begin
          tmr.blink = ~tmr.blink;
          beep_o    = tmr.blink;
        end else begin
          // count down with borrow on every fourth counting tick
          if (tmr.ph == PH_COUNTING) begin
            tmr.ticks = tmr.ticks + 2'd1;
            if (tmr.ticks == TICK_STEP) begin
              if (tmr.secs == 0 && tmr.mins == 0 && tmr.hrs == 0) begin
                tmr.ph = PH_FINISHED;
                alarm_cnt++;
              end else if (tmr.secs == 0 && tmr.mins != 0) begin
                tmr.secs = MS_MAX;
                tmr.mins = tmr.mins - 1'b1;
              end else if (tmr.secs == 0) begin
                tmr.hrs  = tmr.hrs - 1'b1;
                tmr.mins = MS_MAX;
                tmr.secs = MS_MAX;
              end else begin
                tmr.secs = tmr.secs - 1'b1;
              end
            end
          end
          // blink the digit under entry unless the clock is being shown
          if (!tmr.clk_req && tmr.ph == PH_SETUP) begin
            tmr.blink = ~tmr.blink;
            blank_o   = tmr.blink;
          end
        end
      end
      MODE_KEY: begin
        tmr.clk_req = 1'b0;
        used_o      = 1'b1;
        if (tmr.ph == PH_SETUP) begin
          // any key tagged like a digit is taken, low nibble as value
          if (k[5:4] == DIGIT_TAG) begin
            case (tmr.pos)
              POS_HRS_TENS: if (d <= TENS_MAX) begin
                tmr.hrs = with_tens(tmr.hrs, d);
                tmr.pos = POS_HRS_UNIT;
              end
              POS_HRS_UNIT: begin
                tmr.hrs = with_units(tmr.hrs, d);
                tmr.pos = POS_MIN_TENS;
              end
              POS_MIN_TENS: if (d <= TENS_MAX) begin
                tmr.mins = with_tens(tmr.mins, d);
                tmr.pos  = POS_MIN_UNIT;
              end
              POS_MIN_UNIT: begin
                tmr.mins = with_units(tmr.mins, d);
                tmr.pos  = POS_SEC_TENS;
              end
              POS_SEC_TENS: if (d <= TENS_MAX) begin
                tmr.secs = with_tens(tmr.secs, d);
                tmr.pos  = POS_SEC_UNIT;
              end
              POS_SEC_UNIT: begin
                tmr.secs = with_units(tmr.secs, d);
                store_preset();
                tmr.ph = PH_READY;
              end
              default: ;
            endcase
          end
        end else if (k == KEY_PLUS) begin
          if (tmr.ph == PH_COUNTING) tmr.ph = PH_READY;
          else if (tmr.ph == PH_READY) tmr.ph = PH_COUNTING;
          used_o = (tmr.ph != PH_COUNTING);
        end else if (k == KEY_ZERO) begin
          if (tmr.ph == PH_READY || tmr.ph == PH_FINISHED) begin
            reload_preset();
            tmr.ph = PH_READY;
          end
          used_o = (tmr.ph != PH_COUNTING);
        end else if (k == KEY_SLASH) begin
          tmr.clk_req = 1'b1;
          used_o      = (tmr.ph != PH_COUNTING);
        end
      end
      MODE_EXIT: begin
        used_o = 1'b1;
        if (tmr.ph == PH_SETUP) begin
          // skip to the next digit; skipping past the seconds units saves the preset
          tmr.pos = tmr.pos - 3'd1;
          if (tmr.pos == POS_NONE) begin
            store_preset();
            tmr.ph = PH_READY;
          end
        end else if (tmr.ph == PH_FINISHED) begin
          reload_preset();
          tmr.ph = PH_READY;
        end else if (tmr.ph == PH_COUNTING) begin
          tmr.ph = PH_READY;
        end else begin
          used_o = 1'b0;
        end
      end
      default: begin
        reload_preset();
        tmr.ph = PH_READY;
      end
    endcase
    w.hours_bcd      = bcd_of(tmr.hrs);
    w.minutes_bcd    = bcd_of(tmr.mins);
    w.seconds_bcd    = bcd_of(tmr.secs);
    w.phase          = tmr.ph;
    w.setup_position = (tmr.ph == PH_SETUP) ? tmr.pos : POS_NONE;
    w.colon_on       = tmr.ticks[1];
    w.beep           = beep_o;
    w.blank_digit    = blank_o;
    w.show_clock     = tmr.clk_req;
    w.handled        = used_o;
    return w;
  endfunction

  // ----------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [7:0] expv,
                                      input logic [7:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %h, got %h", name, expv, actv);
      err_cnt++;
    end
  endfunction

  task automatic check_word(input logic [OUT_TDATA_W-1:0] d);
    timer_word_t w;
    if (due_words.size() == 0) begin
      $error("result word %h arrived with nothing pending", d);
      err_cnt++;
    end else begin
      w = due_words.pop_front();
      check_field("hours_bcd",      8'(w.hours_bcd),      8'(d[6:0]));
      check_field("minutes_bcd",    8'(w.minutes_bcd),    8'(d[13:7]));
      check_field("seconds_bcd",    8'(w.seconds_bcd),    8'(d[20:14]));
      check_field("phase",          8'(w.phase),          8'(d[22:21]));
      check_field("setup_position", 8'(w.setup_position), 8'(d[25:23]));
      check_field("colon_on",       8'(w.colon_on),       8'(d[26]));
      check_field("beep",           8'(w.beep),           8'(d[27]));
      check_field("blank_digit",    8'(w.blank_digit),    8'(d[28]));
      check_field("show_clock",     8'(w.show_clock),     8'(d[29]));
      check_field("handled",        8'(w.handled),        8'(d[30]));
      check_field("pad",            8'd0,                 8'(d[31]));
      checked_cnt++;
    end
  endtask

  // Take result words and draw a stall after each one
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      check_word(out_tdata);
      rx_wait = rx_idle ? $urandom_range(0, 10) : 0;
      if ($urandom_range(0, 39) == 0) rx_idle = ~rx_idle;
    end
    if (rx_held) begin
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here
  initial forever begin
    @(rx_hold_ev);
    rx_held <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_held <= 1'b0;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // ----------------------------------------------------------------- stimulus

  // Offer one event word, after a random gap when tx_idle is set, and hold it until taken
  task automatic send_event(input mode_t m, input logic [7:0] k, input logic set_btn);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= IN_TDATA_W'({set_btn, k});
    do @(posedge clk); while (in_tready !== 1'b1);
    due_words.push_back(advance_timer(m, k, set_btn));
    sent_cnt++;
  endtask

  task automatic tick(input logic set_btn);
    send_event(MODE_TICK, 8'($urandom), set_btn);
  endtask

  task automatic press(input logic [7:0] k);
    send_event(MODE_KEY, k, 1'($urandom));
  endtask

  task automatic exit_event();
    send_event(MODE_EXIT, 8'($urandom), 1'($urandom));
  endtask

  task automatic enter_event();
    send_event(MODE_ENTER, 8'($urandom), 1'($urandom));
  endtask

  task automatic noise_event();
    send_event(mode_t'(2'($urandom_range(0, 3))), 8'($urandom), 1'($urandom));
  endtask

  function automatic logic [7:0] digit_code(input int d);
    logic [1:0] hi;
    hi = $urandom_range(0, 1) ? 2'b00 : 2'($urandom_range(0, 3));
    return {hi, DIGIT_TAG, 4'(d)};
  endfunction

  // Hold the input idle until every pending word has come back
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_words.size() != 0);
  endtask

  // Bring the timer back to ready from whatever phase it is in
  task automatic leave_to_ready();
    case (tmr.ph)
      PH_COUNTING: press(KEY_PLUS);
      PH_SETUP:    tick(1'b1);
      PH_FINISHED: begin
        case ($urandom_range(0, 2))
          0:       exit_event();
          1:       press(KEY_ZERO);
          default: enter_event();
        endcase
      end
      default: ;
    endcase
  endtask

  // Directed: clock request, rejected tens digit, digit skip, digit entry
  task automatic test_setup_entry();
    press(KEY_SLASH);
    tick(1'b1);
    tick(1'b0);
    press(KEY_ZERO + 8'd6);
    tick(1'b0);
    press(KEY_ZERO);
    press(KEY_ZERO);
    exit_event();
    press(KEY_ZERO);
    exit_event();
    press(KEY_ZERO + 8'd1);
  endtask

  // Directed: run the one-second preset out, alarm, restore, enter, idle exit
  task automatic test_countdown_to_alarm();
    press(KEY_PLUS);
    repeat (7) tick(1'b0);
    tick(1'b0);
    tick(1'b1);
    press(KEY_ZERO);
    enter_event();
    send_event(MODE_EXIT, 8'hFF, 1'b1);
    send_event(MODE_KEY, 8'h00, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_output_stall();
    tx_idle = 1'b0;
    -> rx_hold_ev;
    repeat (40) noise_event();
    tx_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (6) noise_event();
    pause_until_drained();
  endtask

  // Setup with random digits; short presets keep later countdowns brief
  task automatic run_setup_session();
    bit short_preset;
    int guard;
    int d;
    logic [7:0] k;
    short_preset = $urandom_range(0, 1);
    leave_to_ready();
    tick(1'b1);
    guard = 0;
    while (tmr.ph == PH_SETUP && guard < 40) begin
      guard++;
      case ($urandom_range(0, 15))
        0, 1: tick(1'b0);
        2:    exit_event();
        3:    tick($urandom_range(0, 3) == 0);
        4: begin
          k = 8'($urandom);
          if (k[5:4] == DIGIT_TAG) k[4] = 1'b0;
          press(k);
        end
        default: begin
          if (tmr.pos == POS_HRS_TENS || tmr.pos == POS_MIN_TENS || tmr.pos == POS_SEC_TENS) begin
            if ($urandom_range(0, 7) == 0) d = $urandom_range(6, 15);
            else if (short_preset) d = (tmr.pos == POS_SEC_TENS) ? $urandom_range(0, 1) : 0;
            else d = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 5);
          end else begin
            if (short_preset) d = (tmr.pos == POS_SEC_UNIT) ? $urandom_range(0, 9) : 0;
            else if ($urandom_range(0, 5) == 0) d = $urandom_range(10, 15);
            else d = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
          end
          press(digit_code(d));
        end
      endcase
    end
  endtask

  // Start the count and tick, with pauses, clock requests and stray set presses
  task automatic run_count_session();
    int n;
    if (tmr.ph == PH_SETUP) tick(1'b1);
    if (tmr.ph == PH_FINISHED) press(KEY_ZERO);
    if (tmr.ph == PH_READY) press(KEY_PLUS);
    n = $urandom_range(4, 90);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0:       press(KEY_SLASH);
        1:       press(KEY_PLUS);
        2:       tick(1'b1);
        default: tick(1'b0);
      endcase
    end
    if (tmr.ph == PH_FINISHED) leave_to_ready();
  endtask

  task automatic test_random_sessions();
    int goal;
    goal = sent_cnt + RANDOM_ITEMS;
    while (sent_cnt < goal) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2:    run_setup_session();
        3, 4, 5, 6: run_count_session();
        7, 8:       repeat ($urandom_range(1, 8)) noise_event();
        default: begin
          case ($urandom_range(0, 3))
            0:       press(KEY_SLASH);
            1:       press(KEY_ZERO);
            2:       enter_event();
            default: exit_event();
          endcase
          if ($urandom_range(0, 4) == 0) pause_until_drained();
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    tmr.ph      = PH_READY;
    tmr.hrs     = 7'd0;
    tmr.mins    = 7'd5;
    tmr.secs    = 7'd0;
    tmr.pre_h   = 7'd0;
    tmr.pre_m   = 7'd5;
    tmr.pre_s   = 7'd0;
    tmr.ticks   = 2'd0;
    tmr.blink   = 1'b0;
    tmr.pos     = POS_NONE;
    tmr.clk_req = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_setup_entry();
    test_countdown_to_alarm();
    test_output_stall();
    test_drain_pause();
    test_random_sessions();

    // drain, then allow for the pipeline before the verdict
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_words.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d event words sent, %0d result words checked", sent_cnt, checked_cnt);
    $display("summary: %0d presets stored, %0d countdowns run to zero", preset_cnt, alarm_cnt);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/hmsct_pkg.sv
rtl/core/hmsct_step.sv
rtl/core/hms_countdown_timer.sv
rtl/core/hmsct_checker.sv
tb/sv/hms_countdown_timer_tb.sv
